@@ design/tve_pkg.sv @@
// tve_pkg: shared types, constants and helpers of the tag value extractor
`timescale 1ns / 1ps

package tve_pkg;

  // window depth, longest tag that can be matched (1..8)
  localparam int MAX_TAG_LEN = 8;
  localparam int LEN_W       = $clog2(MAX_TAG_LEN + 1);
  localparam int IDX_W       = (MAX_TAG_LEN > 1) ? $clog2(MAX_TAG_LEN) : 1;

  // configuration register indexes
  localparam logic [1:0] CFG_TAG_CHARS  = 2'd0;
  localparam logic [1:0] CFG_TAG_LENGTH = 2'd1;

  // special characters
  localparam logic [7:0] CH_CLOSE   = 8'h3E;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;

  typedef enum logic [1:0] {
    PH_SEARCH  = 2'd0,
    PH_WAIT_EQ = 2'd1,
    PH_SKIP    = 2'd2,
    PH_VALUE   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_BYTE    = 2'd0,
    ST_DONE    = 2'd1,
    ST_DROPPED = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // one result item
  typedef struct packed {
    status_t    status;
    logic [7:0] value_byte;
  } res_t;

  // window control from the sequencer to the cell row
  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctl_t;

  // ascii letters a..z fold to upper case, everything else as is
  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

  // tag length in use: zero acts as one, large values saturate
  function automatic logic [LEN_W-1:0] used_len(input logic [3:0] len);
    logic [LEN_W-1:0] r;
    if (len == 4'd0) begin
      r = LEN_W'(1);
    end else if (32'(len) > MAX_TAG_LEN) begin
      r = LEN_W'(MAX_TAG_LEN);
    end else begin
      r = LEN_W'(len);
    end
    return r;
  endfunction

endpackage

@@ design/tve_cell.sv @@
// tve_cell: one window position, holds a byte and compares it to its tag character
`timescale 1ns / 1ps

module tve_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  tve_pkg::win_ctl_t win_ctl,
  input  logic [7:0]       byte_i,
  input  logic             vld_i,
  input  logic [7:0]       tag_byte,
  input  logic             in_use,
  output logic [7:0]       byte_o,
  output logic             vld_o,
  output logic             hit
);
  import tve_pkg::*;

  logic [7:0] byte_r;
  logic       vld_r;

  // compare the byte this cell takes on the shift against its tag character
  assign hit = !in_use || (vld_i && (fold_upper(byte_i) == fold_upper(tag_byte)));

  // valid flag, cleared with the window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (win_ctl.clear) begin
      vld_r <= 1'b0;
    end else if (win_ctl.shift) begin
      vld_r <= vld_i;
    end
  end

  // byte storage
  always_ff @(posedge clk) begin
    if (win_ctl.shift && !win_ctl.clear) begin
      byte_r <= byte_i;
    end
  end

  assign byte_o = byte_r;
  assign vld_o  = vld_r;

endmodule

@@ design/tve_ctrl.sv @@
// tve_ctrl: phase sequencer, value capture and result generation
`timescale 1ns / 1ps

module tve_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        in_byte,
  input  logic              in_end_of_file,
  input  logic              match,
  output logic              res_vld,
  output tve_pkg::res_t     res,
  output tve_pkg::win_ctl_t win_ctl
);
  import tve_pkg::*;

  phase_t phase_r, phase_nxt;
  logic   quote_r, quote_nxt;

  logic is_quote, is_blank, is_end;
  logic val_active, val_q, val_open, val_done;

  // character classes
  assign is_quote = (in_byte == CH_QUOTE);
  assign is_blank = (in_byte == CH_SPACE) || (in_byte == CH_NEWLINE);
  assign is_end   = is_blank || (in_byte == CH_CLOSE);

  // value byte handling, first byte after blanks starts unquoted
  assign val_active = (phase_r == PH_VALUE) || ((phase_r == PH_SKIP) && !is_blank);
  assign val_q      = (phase_r == PH_VALUE) ? quote_r : 1'b0;
  assign val_open   = !val_q && is_quote;
  assign val_done   = (val_q && is_quote) || (!val_q && is_end);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    quote_nxt = quote_r;
    if (acc) begin
      if (in_end_of_file) begin
        phase_nxt = PH_SEARCH;
        quote_nxt = 1'b0;
      end else begin
        case (phase_r)
          PH_SEARCH: begin
            if (match) begin
              phase_nxt = PH_WAIT_EQ;
            end
          end
          PH_WAIT_EQ: begin
            if (in_byte == CH_EQUAL) begin
              phase_nxt = PH_SKIP;
            end
          end
          PH_SKIP, PH_VALUE: begin
            if (val_active) begin
              if (val_open) begin
                phase_nxt = PH_VALUE;
                quote_nxt = 1'b1;
              end else if (val_done) begin
                phase_nxt = PH_SEARCH;
                quote_nxt = 1'b0;
              end else begin
                phase_nxt = PH_VALUE;
                quote_nxt = val_q;
              end
            end
          end
          default: begin
            phase_nxt = PH_SEARCH;
          end
        endcase
      end
    end
  end

  // outputs: result item and window control
  always_comb begin
    res_vld            = 1'b0;
    res.status         = ST_BYTE;
    res.value_byte     = 8'h00;
    win_ctl.shift      = 1'b0;
    win_ctl.clear      = 1'b0;
    if (acc) begin
      if (in_end_of_file) begin
        win_ctl.clear = 1'b1;
        case (phase_r)
          PH_VALUE: begin
            res_vld    = 1'b1;
            res.status = ST_DROPPED;
          end
          PH_WAIT_EQ, PH_SKIP: begin
            res_vld    = 1'b1;
            res.status = ST_MISSING;
          end
          default: begin
            res_vld = 1'b0;
          end
        endcase
      end else if (phase_r == PH_SEARCH) begin
        win_ctl.shift = 1'b1;
        win_ctl.clear = match;
      end else if (val_active && !val_open) begin
        res_vld = 1'b1;
        if (val_done) begin
          res.status    = ST_DONE;
          win_ctl.clear = 1'b1;
        end else begin
          res.value_byte = in_byte;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      quote_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      quote_r <= quote_nxt;
    end
  end

endmodule

@@ design/tve_obuf.sv @@
// tve_obuf: output register with a skid stage for the result channel
`timescale 1ns / 1ps

module tve_obuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_vld,
  input  tve_pkg::res_t res,
  input  logic          out_stall,
  output logic          out_valid,
  output tve_pkg::res_t out_res,
  output logic          full
);
  import tve_pkg::*;

  logic out_vld_r, out_vld_nxt;
  logic skid_vld_r, skid_vld_nxt;
  res_t out_res_r, out_res_nxt;
  res_t skid_res_r, skid_res_nxt;
  logic pop;

  assign pop = out_vld_r && !out_stall;

  // refill from skid first, new items land in skid only while the head waits
  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_res_nxt  = out_res_r;
    skid_res_nxt = skid_res_r;
    if (skid_vld_r) begin
      if (pop) begin
        out_res_nxt  = skid_res_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (res_vld) begin
      if (!out_vld_r || pop) begin
        out_res_nxt = res;
        out_vld_nxt = 1'b1;
      end else begin
        skid_res_nxt = res;
        skid_vld_nxt = 1'b1;
      end
    end else if (pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_res_r;
  assign full      = skid_vld_r;

endmodule

@@ design/tag_value_extractor.sv @@
// tag_value_extractor: top level, cell row for the tag window plus sequencer
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | in_byte, in_end_of_file
//   out_    | output    | out_valid/out_stall | out_status, out_value_byte
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one item per cycle while in_stall is low; each cell compares its incoming byte
// in the cycle of the shift; a result goes to out_ through the output register, or
// through the skid stage first while an earlier result still waits on out_stall
// reset clears the window, the phase and both output stages; tag_length resets to 1
// an output register and a skid stage buffer results; in_stall rises only while the
// skid stage holds an item, and cfg_ready is always high
`timescale 1ns / 1ps

module tag_value_extractor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_value_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import tve_pkg::*;

  logic [63:0]      tag_chars_r;
  logic [3:0]       tag_length_r;
  logic [LEN_W-1:0] len;
  logic             acc;
  logic             match;
  logic             res_vld;
  res_t             res;
  res_t             out_res;
  win_ctl_t         win_ctl;
  logic             full;

  logic [7:0]             cell_byte [MAX_TAG_LEN+1];
  logic                   cell_vld  [MAX_TAG_LEN+1];
  logic [MAX_TAG_LEN-1:0] hits;

  assign cfg_ready = 1'b1;
  assign acc       = in_valid && !in_stall;
  assign len       = used_len(tag_length_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_chars_r  <= 64'h0;
      tag_length_r <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TAG_CHARS:  tag_chars_r  <= cfg_data;
        CFG_TAG_LENGTH: tag_length_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // window row, newest byte enters at cell 0
  assign cell_byte[0] = in_byte;
  assign cell_vld[0]  = 1'b1;

  for (genvar i = 0; i < MAX_TAG_LEN; i++) begin : g_cell
    logic [IDX_W-1:0] tag_pos;
    logic             in_use;

    // cell i lines up with tag character len-1-i
    assign tag_pos = IDX_W'(len - LEN_W'(i + 1));
    assign in_use  = LEN_W'(i) < len;

    tve_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .win_ctl  (win_ctl),
      .byte_i   (cell_byte[i]),
      .vld_i    (cell_vld[i]),
      .tag_byte (tag_chars_r[8*tag_pos +: 8]),
      .in_use   (in_use),
      .byte_o   (cell_byte[i+1]),
      .vld_o    (cell_vld[i+1]),
      .hit      (hits[i])
    );
  end

  assign match = &hits;

  tve_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (acc),
    .in_byte        (in_byte),
    .in_end_of_file (in_end_of_file),
    .match          (match),
    .res_vld        (res_vld),
    .res            (res),
    .win_ctl        (win_ctl)
  );

  tve_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .full      (full)
  );

  assign in_stall       = full;
  assign out_status     = out_res.status;
  assign out_value_byte = out_res.value_byte;

endmodule

@@ design/tve_checker.sv @@
// tve_checker: port level assertions for the tag value extractor, bound to the top
`timescale 1ns / 1ps

module tve_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [7:0]  out_value_byte,
  input logic        cfg_ready
);
  import tve_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_value_byte))
    else $error("stalled result changed");

  // only value bytes carry data
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_BYTE) |-> out_value_byte == 8'h00)
    else $error("non-byte result carries data");

  // input backs up only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && $past(out_valid) && $past(out_stall))
    else $error("input stalled without a waiting result");

  // reset empties both stages
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall && cfg_ready)
    else $error("buffers not empty after reset");

endmodule

bind tag_value_extractor tve_checker u_tve_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_value_byte (out_value_byte),
  .cfg_ready      (cfg_ready)
);

@@ test/tb_tag_value_extractor.sv @@
// tb_tag_value_extractor: self-checking bench for the tag value extractor
`timescale 1ns / 1ps

module tb_tag_value_extractor;
  import tve_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int ITEMS_PER_SET = 115;
  localparam int NUM_SETS      = 6;
  localparam int SETTLE_CYCLES = 6;
  // register indexes past the end of the list, writes there change nothing
  localparam logic [1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI = 2'd3;

  localparam res_t NO_RES = '{ST_BYTE, 8'h00};

  // one directed item, with the result typed in where it is obvious
  typedef struct packed {
    logic [7:0] b;
    logic       eof;
    logic       typed;
    res_t       want;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        in_end_of_file = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [7:0]  out_value_byte;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_TAG_CHARS;
  logic [63:0] cfg_data = 64'h0;

  tag_value_extractor dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .in_end_of_file(in_end_of_file),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_value_byte(out_value_byte),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // expected extractor state and settings
  logic [7:0]  hist [MAX_TAG_LEN];
  int          hist_cnt;
  phase_t      scan_ph;
  bit          in_quotes;
  logic [63:0] exp_tag;
  logic [3:0]  exp_len;
  res_t        pending_results [$];

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int errs = 0;
  int cycles = 0;
  int items_sent = 0;
  int results_seen = 0;
  int sets = 0;
  int status_cnt [4] = '{0, 0, 0, 0};

  // directed items, all under the reset settings (tag of one zero byte)
  step_row_t directed [27] = '{
    '{8'h00,      1'b0, 1'b0, NO_RES},
    '{CH_EQUAL,   1'b0, 1'b0, NO_RES},
    '{CH_SPACE,   1'b0, 1'b0, NO_RES},
    '{CH_NEWLINE, 1'b0, 1'b0, NO_RES},
    '{"A",        1'b0, 1'b1, '{ST_BYTE, "A"}},
    '{CH_QUOTE,   1'b0, 1'b0, NO_RES},
    '{CH_SPACE,   1'b0, 1'b1, '{ST_BYTE, CH_SPACE}},
    '{CH_CLOSE,   1'b0, 1'b1, '{ST_BYTE, CH_CLOSE}},
    '{CH_QUOTE,   1'b0, 1'b1, '{ST_DONE, 8'h00}},
    '{8'hFF,      1'b1, 1'b0, NO_RES},
    '{8'h00,      1'b0, 1'b0, NO_RES},
    '{8'hFF,      1'b1, 1'b1, '{ST_MISSING, 8'h00}},
    '{8'h00,      1'b0, 1'b0, NO_RES},
    '{CH_EQUAL,   1'b0, 1'b0, NO_RES},
    '{8'h00,      1'b1, 1'b1, '{ST_MISSING, 8'h00}},
    '{8'h00,      1'b0, 1'b0, NO_RES},
    '{CH_EQUAL,   1'b0, 1'b0, NO_RES},
    '{CH_QUOTE,   1'b0, 1'b0, NO_RES},
    '{8'hFF,      1'b0, 1'b1, '{ST_BYTE, 8'hFF}},
    '{8'h00,      1'b1, 1'b1, '{ST_DROPPED, 8'h00}},
    '{8'h00,      1'b0, 1'b0, NO_RES},
    '{CH_EQUAL,   1'b0, 1'b0, NO_RES},
    '{CH_CLOSE,   1'b0, 1'b1, '{ST_DONE, 8'h00}},
    '{8'h00,      1'b0, 1'b0, NO_RES},
    '{CH_EQUAL,   1'b0, 1'b0, NO_RES},
    '{"x",        1'b0, 1'b1, '{ST_BYTE, "x"}},
    '{CH_NEWLINE, 1'b0, 1'b1, '{ST_DONE, 8'h00}}
  };

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] to_upper_ascii(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  // tag characters that take part in the compare
  function automatic int tag_span(input logic [3:0] len);
    if (len == 4'd0) begin
      return 1;
    end
    if (len > MAX_TAG_LEN) begin
      return MAX_TAG_LEN;
    end
    return len;
  endfunction

  function automatic void forget_hist();
    foreach (hist[i]) hist[i] = 8'h00;
    hist_cnt = 0;
  endfunction

  // tail of the history against the tag, oldest byte against first tag char
  function automatic bit tag_seen();
    int n;
    n = tag_span(exp_len);
    if (hist_cnt < n) begin
      return 1'b0;
    end
    for (int k = 0; k < n; k++) begin
      if (to_upper_ascii(exp_tag[8*k +: 8]) != to_upper_ascii(hist[n-1-k])) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // one byte inside a value: open quote, finish or emit
  function automatic bit value_char(input logic [7:0] c, output res_t r);
    scan_ph = PH_VALUE;
    r = '{ST_BYTE, c};
    if (!in_quotes && c == CH_QUOTE) begin
      in_quotes = 1'b1;
      return 1'b0;
    end
    if ((in_quotes && c == CH_QUOTE) ||
        (!in_quotes && (c == CH_SPACE || c == CH_NEWLINE || c == CH_CLOSE))) begin
      in_quotes = 1'b0;
      scan_ph = PH_SEARCH;
      forget_hist();
      r = '{ST_DONE, 8'h00};
    end
    return 1'b1;
  endfunction

  // expected result of one accepted item, if any
  function automatic bit next_result(input logic [7:0] b, input bit eof, output res_t r);
    bit hit;
    hit = 1'b0;
    r = NO_RES;
    if (eof) begin
      if (scan_ph == PH_VALUE) begin
        r = '{ST_DROPPED, 8'h00};
        hit = 1'b1;
      end else if (scan_ph != PH_SEARCH) begin
        r = '{ST_MISSING, 8'h00};
        hit = 1'b1;
      end
      forget_hist();
      scan_ph = PH_SEARCH;
      in_quotes = 1'b0;
      return hit;
    end
    case (scan_ph)
      PH_SEARCH: begin
        for (int i = MAX_TAG_LEN - 1; i > 0; i--) hist[i] = hist[i-1];
        hist[0] = b;
        if (hist_cnt < MAX_TAG_LEN) hist_cnt++;
        if (tag_seen()) begin
          forget_hist();
          scan_ph = PH_WAIT_EQ;
        end
      end
      PH_WAIT_EQ: begin
        if (b == CH_EQUAL) scan_ph = PH_SKIP;
      end
      PH_SKIP: begin
        if (b != CH_SPACE && b != CH_NEWLINE) begin
          in_quotes = 1'b0;
          hit = value_char(b, r);
        end
      end
      default: begin
        hit = value_char(b, r);
      end
    endcase
    return hit;
  endfunction

  // eight random letters of mixed case
  function automatic logic [63:0] letter_tag();
    logic [63:0] t;
    for (int k = 0; k < 8; k++) begin
      t[8*k +: 8] = 8'h41 + 8'($urandom_range(25)) + ($urandom_range(1) ? 8'h20 : 8'h00);
    end
    return t;
  endfunction

  // spare index first, then both registers
  task automatic write_tag(input logic [63:0] chars, input logic [3:0] len);
    logic [63:0] lw;
    lw = {$urandom, $urandom};
    lw[3:0] = len;
    cfg_valid <= 1'b1;
    cfg_index <= $urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO;
    cfg_data  <= {$urandom, $urandom};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_TAG_CHARS;
    cfg_data  <= chars;
    do @(posedge clk); while (!cfg_ready);
    exp_tag = chars;
    cfg_index <= CFG_TAG_LENGTH;
    cfg_data  <= lw;
    do @(posedge clk); while (!cfg_ready);
    exp_len = lw[3:0];
    cfg_valid <= 1'b0;
    sets++;
  endtask

  // send one item, predict its result once accepted
  task automatic push_char(input logic [7:0] b, input bit eof, input bit typed,
                           input res_t want);
    res_t r;
    bit   hit;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_byte        <= b;
    in_end_of_file <= eof;
    do @(posedge clk); while (in_stall);
    hit = next_result(b, eof, r);
    if (typed) begin
      pending_results.insert(pending_results.size(), want);
    end else if (hit) begin
      pending_results.insert(pending_results.size(), r);
    end
    items_sent++;
  endtask

  // wait until every result is in, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin : check_out
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      status_cnt[out_status]++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d byte %02h",
                 $time, out_status, out_value_byte);
        errs++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, out_status);
          errs++;
        end
        if (out_value_byte !== want.value_byte) begin
          $display("%0t: value byte mismatch, expected %02h, got %02h",
                   $time, want.value_byte, out_value_byte);
          errs++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < snk_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles, %0d results outstanding",
               $time, cycles, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    logic [8:0]  seq [$];
    logic [63:0] chars;
    logic [3:0]  len;
    logic [7:0]  c;
    bit          quoted;
    int          n;
    int          base;
    int          cut;
    exp_tag = 64'h0;
    exp_len = 4'd1;
    forget_hist();
    scan_ph = PH_SEARCH;
    in_quotes = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items with the reset settings
    src_idle_pct = 15;
    snk_idle_pct = 81;
    foreach (directed[i]) begin
      push_char(directed[i].b, directed[i].eof, directed[i].typed, directed[i].want);
    end
    drain();

    for (int s = 0; s < NUM_SETS; s++) begin
      // idle pattern per pair of settings
      case (s / 2)
        0: begin
          src_idle_pct = 15;
          snk_idle_pct = 81;
        end
        1: begin
          src_idle_pct = 81;
          snk_idle_pct = 15;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      case (s)
        0: begin
          chars = '1;
          len = 4'hF;
        end
        1: begin
          chars = letter_tag();
          len = 4'h0;
        end
        2: begin
          chars = '0;
          len = 4'd8;
        end
        3: begin
          chars = letter_tag();
          len = 4'd8;
        end
        4: begin
          chars = {$urandom, $urandom};
          len = 4'($urandom_range(8, 1));
        end
        default: begin
          chars = letter_tag();
          len = 4'($urandom_range(7, 1));
        end
      endcase
      write_tag(chars, len);
      n = tag_span(len);
      base = items_sent;

      while (items_sent - base < ITEMS_PER_SET) begin
        seq.delete();
        if ($urandom_range(9) < 7) begin
          // well formed record: noise, tag, junk, '=', blanks, value, end mark
          repeat ($urandom_range(3)) seq.insert(seq.size(), {1'b0, 8'($urandom)});
          for (int k = 0; k < n; k++) begin
            c = chars[8*k +: 8];
            if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(1)) begin
              c = c ^ 8'h20;
            end
            seq.insert(seq.size(), {1'b0, c});
          end
          repeat ($urandom_range(2)) seq.insert(seq.size(), {1'b0, 8'($urandom)});
          seq.insert(seq.size(), {1'b0, CH_EQUAL});
          repeat ($urandom_range(2)) begin
            seq.insert(seq.size(), {1'b0, ($urandom_range(1) ? CH_SPACE : CH_NEWLINE)});
          end
          quoted = $urandom_range(1);
          if (quoted) seq.insert(seq.size(), {1'b0, CH_QUOTE});
          cut = $urandom_range(6);
          for (int k = 0; k < cut; k++) begin
            do c = 8'($urandom);
            while (c == CH_QUOTE ||
                   (!quoted && (c == CH_SPACE || c == CH_NEWLINE || c == CH_CLOSE)));
            seq.insert(seq.size(), {1'b0, c});
            // a quote in an unquoted value switches quoting on
            if (!quoted && $urandom_range(9) == 0) begin
              seq.insert(seq.size(), {1'b0, CH_QUOTE});
              quoted = 1'b1;
            end
          end
          if (quoted) begin
            seq.insert(seq.size(), {1'b0, CH_QUOTE});
          end else if (cut == 0) begin
            seq.insert(seq.size(), {1'b0, CH_CLOSE});
          end else begin
            case ($urandom_range(2))
              0: seq.insert(seq.size(), {1'b0, CH_SPACE});
              1: seq.insert(seq.size(), {1'b0, CH_NEWLINE});
              default: seq.insert(seq.size(), {1'b0, CH_CLOSE});
            endcase
          end
          // cut short by end of file now and then
          if ($urandom_range(6) == 0) begin
            cut = $urandom_range(seq.size() - 1, 1);
            while (seq.size() > cut) void'(seq.pop_back());
            seq.insert(seq.size(), {1'b1, 8'($urandom)});
          end else if ($urandom_range(9) == 0) begin
            seq.insert(seq.size(), {1'b1, 8'($urandom)});
          end
        end else begin
          // noise with the odd end of file
          repeat ($urandom_range(6, 1)) begin
            seq.insert(seq.size(), {($urandom_range(7) == 0), 8'($urandom)});
          end
        end
        foreach (seq[j]) push_char(seq[j][7:0], seq[j][8], 1'b0, NO_RES);
      end
      drain();
    end

    $display("checked %0d results from %0d items over %0d tag settings and three idle patterns",
             results_seen, items_sent, sets);
    $display("value bytes %0d, completed %0d, dropped at end %0d, missing at end %0d",
             status_cnt[ST_BYTE], status_cnt[ST_DONE], status_cnt[ST_DROPPED],
             status_cnt[ST_MISSING]);
    if (errs == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ tag_value_extractor.f @@
design/tve_pkg.sv
design/tve_cell.sv
design/tve_ctrl.sv
design/tve_obuf.sv
design/tag_value_extractor.sv
design/tve_checker.sv
test/tb_tag_value_extractor.sv
